// File: hdl/irn_pkg.sv
// ----------------------------------------------------------------------------
// irn_pkg : shared types and constants for the nearest-pixel rotator
// Register indexes, field widths, parameter defaults and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package irn_pkg;

    localparam int SRC_MAX_SIDE_DEF = 256;
    localparam int FRAC_BITS_DEF    = 14;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TRIG_W     = 16;
    localparam int SIZE_W     = 9;
    localparam int COORD_W    = 8;
    localparam int PIX_W      = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_COS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_W = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_H = 3'd5;

    localparam logic [TRIG_W-1:0] COS_RST  = 16'h4000;
    localparam logic [TRIG_W-1:0] SIN_RST  = 16'h0000;
    localparam logic [SIZE_W-1:0] SIZE_RST = 9'd256;

    typedef struct packed {
        logic store;
        logic emit;
        logic mul;
        logic sum;
        logic map;
        logic rd;
        logic load;
    } t_irn_cmd;

    typedef struct packed {
        logic out_free;
    } t_irn_stat;

endpackage

`default_nettype wire

// File: hdl/image_rotate_nearest.sv
// ----------------------------------------------------------------------------
// image_rotate_nearest : nearest-pixel image rotation by inverse mapping
// Store beats fill the source frame; emit beats walk the destination frame
// in raster order and return the source pixel each position maps to.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------
//   in      | sink      | i_in_valid / o_in_stall | func, src_x, src_y, pixel_in
//   out     | source    | o_out_valid/i_out_stall | pixel_out, inside_res, col/row,
//           |           |                         | last
//   cfg     | sink      | i_cfg_valid/o_cfg_ready | cfg_index, cfg_data
//
// A store beat writes the frame through its one frame memory write port.
// An emit beat steps through the sequencer: delta, multiply, sum,
// map, registered frame read, output load.
// The output register holds a result while o_out_valid waits on i_out_stall;
// a stalled result delays only the next output load.
// Synchronous active-low reset; the frame memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module image_rotate_nearest
    import irn_pkg::*;
#(
    parameter int SRC_MAX_SIDE = SRC_MAX_SIDE_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_func,
    input  wire logic [COORD_W-1:0]    i_src_x,
    input  wire logic [COORD_W-1:0]    i_src_y,
    input  wire logic [PIX_W-1:0]      i_pixel_in,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [PIX_W-1:0]           o_pixel_out,
    output logic                       o_inside_res,
    output logic [SIZE_W-1:0]          o_dst_col,
    output logic [SIZE_W-1:0]          o_dst_row,
    output logic                       o_last,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_irn_cmd  cmd;
    t_irn_stat stat;

    assign o_cfg_ready = 1'b1;

    irn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    irn_dpath #(
        .SRC_MAX_SIDE (SRC_MAX_SIDE),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_src_x      (i_src_x),
        .i_src_y      (i_src_y),
        .i_pixel_in   (i_pixel_in),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_pixel_out  (o_pixel_out),
        .o_inside_res (o_inside_res),
        .o_dst_col    (o_dst_col),
        .o_dst_row    (o_dst_row),
        .o_last       (o_last)
    );

    a_emit_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_func |=> o_in_stall)
        else $error("input taken during emit processing");

    a_store_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_func && !o_out_valid |=> !o_out_valid)
        else $error("store beat produced a result");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_inside_res |-> o_pixel_out == '0)
        else $error("outside pixel not zero");

endmodule

`default_nettype wire

// File: hdl/irn_ctrl.sv
// ----------------------------------------------------------------------------
// irn_ctrl : sequencer for the rotator
// Accepts one beat at a time and steps an emit through the delta, multiply,
// sum, map, read and output steps of the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module irn_ctrl
    import irn_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_func,
    input  wire t_irn_stat i_stat,
    output logic           o_in_stall,
    output t_irn_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_MAP  = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.store = i_in_valid && !i_func;
                o_cmd.emit  = i_in_valid && i_func;
                if (i_in_valid && i_func) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_MAP;
            end
            S_MAP: begin
                o_cmd.map = 1'b1;
                n_state   = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// File: hdl/irn_dpath.sv
// ----------------------------------------------------------------------------
// irn_dpath : rotator datapath
// Configuration registers, destination counters, inverse-map arithmetic,
// source frame memory and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module irn_dpath
    import irn_pkg::*;
#(
    parameter int SRC_MAX_SIDE = SRC_MAX_SIDE_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_irn_cmd              i_cmd,
    output t_irn_stat                  o_stat,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [COORD_W-1:0]    i_src_x,
    input  wire logic [COORD_W-1:0]    i_src_y,
    input  wire logic [PIX_W-1:0]      i_pixel_in,
    input  wire logic                  i_out_stall,
    output logic                       o_out_valid,
    output logic [PIX_W-1:0]           o_pixel_out,
    output logic                       o_inside_res,
    output logic [SIZE_W-1:0]          o_dst_col,
    output logic [SIZE_W-1:0]          o_dst_row,
    output logic                       o_last
);

    localparam int DLW   = SIZE_W + 2;
    localparam int PW    = TRIG_W + DLW;
    localparam int SUMW  = PW + 2;
    localparam int SIW   = $clog2(SRC_MAX_SIDE);
    localparam int DEPTH = SRC_MAX_SIDE * SRC_MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam logic signed [SUMW-1:0] RND    = SUMW'((1 << FRAC_BITS) - 1);
    localparam logic signed [SUMW-1:0] SIDE_S = SUMW'(SRC_MAX_SIDE);

    logic signed [TRIG_W-1:0] r_cos;
    logic signed [TRIG_W-1:0] r_sin;
    logic [SIZE_W-1:0]        r_src_w;
    logic [SIZE_W-1:0]        r_src_h;
    logic [SIZE_W-1:0]        r_dst_w;
    logic [SIZE_W-1:0]        r_dst_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos   <= COS_RST;
            r_sin   <= SIN_RST;
            r_src_w <= SIZE_RST;
            r_src_h <= SIZE_RST;
            r_dst_w <= SIZE_RST;
            r_dst_h <= SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COS:   r_cos   <= i_cfg_data;
                CFG_SIN:   r_sin   <= i_cfg_data;
                CFG_SRC_W: r_src_w <= i_cfg_data[SIZE_W-1:0];
                CFG_SRC_H: r_src_h <= i_cfg_data[SIZE_W-1:0];
                CFG_DST_W: r_dst_w <= i_cfg_data[SIZE_W-1:0];
                CFG_DST_H: r_dst_h <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // destination raster counters, advanced when an emit beat is taken
    logic [SIZE_W-1:0] r_col;
    logic [SIZE_W-1:0] r_row;
    logic [SIZE_W-1:0] r_col_h;
    logic [SIZE_W-1:0] r_row_h;
    logic              r_last_h;
    logic [SIZE_W-1:0] dw_eff;
    logic [SIZE_W-1:0] dh_eff;
    logic              last_col;
    logic              last_row;
    logic signed [DLW-1:0] r_dx;
    logic signed [DLW-1:0] r_dy;

    assign dw_eff   = (r_dst_w == '0) ? SIZE_W'(1) : r_dst_w;
    assign dh_eff   = (r_dst_h == '0) ? SIZE_W'(1) : r_dst_h;
    assign last_col = ({1'b0, r_col} + (SIZE_W+1)'(1)) >= {1'b0, dw_eff};
    assign last_row = ({1'b0, r_row} + (SIZE_W+1)'(1)) >= {1'b0, dh_eff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.emit) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + SIZE_W'(1);
            end else begin
                r_col <= r_col + SIZE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_col_h  <= r_col;
            r_row_h  <= r_row;
            r_last_h <= last_col && last_row;
            r_dx     <= $signed({2'b00, r_col}) - $signed({3'b000, r_dst_w[SIZE_W-1:1]});
            r_dy     <= $signed({2'b00, r_row}) - $signed({3'b000, r_dst_h[SIZE_W-1:1]});
        end
    end

    // inverse mapping: products, rounded sums, source coordinates
    logic signed [PW-1:0]   r_p0;
    logic signed [PW-1:0]   r_p1;
    logic signed [PW-1:0]   r_p2;
    logic signed [PW-1:0]   r_p3;
    logic signed [SUMW-1:0] r_ax;
    logic signed [SUMW-1:0] r_ay;
    logic signed [SUMW-1:0] r_bx;
    logic signed [SUMW-1:0] r_by;
    logic signed [SUMW-1:0] sw_ext;
    logic signed [SUMW-1:0] sh_ext;
    logic signed [SUMW-1:0] sw_cl;
    logic signed [SUMW-1:0] sh_cl;

    assign sw_ext = $signed(SUMW'(r_src_w));
    assign sh_ext = $signed(SUMW'(r_src_h));
    assign sw_cl  = (sw_ext > SIDE_S) ? SIDE_S : sw_ext;
    assign sh_cl  = (sh_ext > SIDE_S) ? SIDE_S : sh_ext;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_p0 <= r_cos * r_dx;
            r_p1 <= r_sin * r_dy;
            r_p2 <= r_cos * r_dy;
            r_p3 <= r_sin * r_dx;
        end
        if (i_cmd.sum) begin
            r_ax <= SUMW'(r_p0) + SUMW'(r_p1) + RND;
            r_ay <= SUMW'(r_p2) - SUMW'(r_p3) + RND;
        end
        if (i_cmd.map) begin
            r_bx <= (r_ax >>> FRAC_BITS) + (sw_cl >>> 1);
            r_by <= (r_ay >>> FRAC_BITS) + (sh_cl >>> 1);
        end
    end

    // source frame
    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rd_data;
    logic             r_inside;
    logic             map_hit;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic             wr_ok;

    assign wr_ok   = (int'(i_src_x) < SRC_MAX_SIDE) && (int'(i_src_y) < SRC_MAX_SIDE);
    assign wr_addr = AW'(i_src_y) * AW'(SRC_MAX_SIDE) + AW'(i_src_x);
    assign rd_addr = AW'(r_by[SIW-1:0]) * AW'(SRC_MAX_SIDE) + AW'(r_bx[SIW-1:0]);
    assign map_hit = (r_bx >= 0) && (r_bx < sw_cl) && (r_by >= 0) && (r_by < sh_cl);

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && wr_ok) begin
            r_mem[wr_addr] <= i_pixel_in;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[rd_addr];
            r_inside  <= map_hit;
        end
    end

    // output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_pixel_out  <= r_inside ? r_rd_data : '0;
            o_inside_res <= r_inside;
            o_dst_col    <= r_col_h;
            o_dst_row    <= r_row_h;
            o_last       <= r_last_h;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

endmodule

`default_nettype wire

// File: tb/image_rotate_nearest_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// image_rotate_nearest_test : self-checking bench for the nearest-pixel rotator
// Fills the source frame with store beats, walks the destination frame with
// emit beats and checks every result against a local inverse-mapping model.
// Covers rotations, trig extremes, size saturation and counter wrap on shrink.
// ----------------------------------------------------------------------------
module image_rotate_nearest_test;
    import irn_pkg::*;

    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_EMIT  = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd6;

    localparam int REG_CNT = 6;
    localparam logic [REG_CNT-1:0] ALL_REGS  = '1;
    localparam logic [REG_CNT-1:0] TRIG_REGS = (REG_CNT'(1) << CFG_COS) | (REG_CNT'(1) << CFG_SIN);
    localparam logic [REG_CNT-1:0] SIZE_REGS = ALL_REGS & ~TRIG_REGS;

    localparam int SIDE          = SRC_MAX_SIDE_DEF;
    localparam int FRAC          = FRAC_BITS_DEF;
    localparam int TOTAL_ITEMS   = 1750;
    localparam int QUIET_ITEMS   = 250;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 1500000;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic              hit;
        logic [SIZE_W-1:0] col;
        logic [SIZE_W-1:0] row;
        logic              last;
    } t_rot_pixel;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_func      = 1'b0;
    logic [COORD_W-1:0]    i_src_x     = '0;
    logic [COORD_W-1:0]    i_src_y     = '0;
    logic [PIX_W-1:0]      i_pixel_in  = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [PIX_W-1:0]      o_pixel_out;
    logic                  o_inside_res;
    logic [SIZE_W-1:0]     o_dst_col;
    logic [SIZE_W-1:0]     o_dst_row;
    logic                  o_last;
    logic                  o_cfg_ready;

    // model copy of registers, raster counters and source frame
    logic [TRIG_W-1:0] reg_cos   = COS_RST;
    logic [TRIG_W-1:0] reg_sin   = SIN_RST;
    logic [SIZE_W-1:0] reg_src_w = SIZE_RST;
    logic [SIZE_W-1:0] reg_src_h = SIZE_RST;
    logic [SIZE_W-1:0] reg_dst_w = SIZE_RST;
    logic [SIZE_W-1:0] reg_dst_h = SIZE_RST;
    logic [SIZE_W-1:0] next_col  = '0;
    logic [SIZE_W-1:0] next_row  = '0;
    logic [PIX_W-1:0]  frame_copy [SIDE*SIDE];
    t_rot_pixel        pending_pixels [$];

    int gap_pct         = 15;
    int stall_pct       = 15;
    int stall_left      = 0;
    int errors          = 0;
    int cycle_count     = 0;
    int stores_sent     = 0;
    int emits_sent      = 0;
    int results_checked = 0;
    int inside_seen     = 0;
    int last_seen       = 0;
    int settings_count  = 0;

    image_rotate_nearest uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_src_x      (i_src_x),
        .i_src_y      (i_src_y),
        .i_pixel_in   (i_pixel_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_out  (o_pixel_out),
        .o_inside_res (o_inside_res),
        .o_dst_col    (o_dst_col),
        .o_dst_row    (o_dst_row),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            cycle_count <= cycle_count + 1;
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
            stall_left = $urandom_range(0, 11);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic longint ceil_q(longint a);
        longint one;
        one = longint'(1) <<< FRAC;
        if (a >= 0)
            return (a + one - 1) >>> FRAC;
        return -((-a) >>> FRAC);
    endfunction

    // inverse map of the next raster position, advances the counters
    function automatic t_rot_pixel map_next_pixel();
        t_rot_pixel r;
        int sw, sh, dw, dh, col, row;
        longint cs, sn, dx, dy, bx, by;
        sw  = (reg_src_w > SIDE) ? SIDE : reg_src_w;
        sh  = (reg_src_h > SIDE) ? SIDE : reg_src_h;
        dw  = (reg_dst_w == 0) ? 1 : reg_dst_w;
        dh  = (reg_dst_h == 0) ? 1 : reg_dst_h;
        col = next_col;
        row = next_row;
        cs  = $signed(reg_cos);
        sn  = $signed(reg_sin);
        dx  = col - dw / 2;
        dy  = row - dh / 2;
        bx  = ceil_q(cs * dx + sn * dy) + sw / 2;
        by  = ceil_q(cs * dy - sn * dx) + sh / 2;
        r.hit   = (bx >= 0 && bx < sw && by >= 0 && by < sh);
        r.pixel = r.hit ? frame_copy[int'(by) * SIDE + int'(bx)] : '0;
        r.col   = SIZE_W'(col);
        r.row   = SIZE_W'(row);
        r.last  = (col + 1 >= dw) && (row + 1 >= dh);
        if (col + 1 >= dw) begin
            next_col = '0;
            next_row = (row + 1 >= dh) ? '0 : SIZE_W'(row + 1);
        end else begin
            next_col = SIZE_W'(col + 1);
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [PIX_W-1:0] want,
                                 input logic [PIX_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : check_output
        t_rot_pixel want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected result beat at col %0d row %0d", o_dst_col, o_dst_row);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                compare_field("pixel_out", want.pixel, o_pixel_out);
                compare_field("inside_res", PIX_W'(want.hit), PIX_W'(o_inside_res));
                compare_field("dst_col", PIX_W'(want.col), PIX_W'(o_dst_col));
                compare_field("dst_row", PIX_W'(want.row), PIX_W'(o_dst_row));
                compare_field("last", PIX_W'(want.last), PIX_W'(o_last));
                results_checked++;
                if (o_inside_res === 1'b1)
                    inside_seen++;
                if (o_last === 1'b1)
                    last_seen++;
            end
        end
    end

    task automatic send_beat(input logic func, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [PIX_W-1:0] pix);
        int gap;
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            gap = $urandom_range(1, 12);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_src_x    <= x;
        i_src_y    <= y;
        i_pixel_in <= pix;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        if (func == FUNC_STORE) begin
            frame_copy[{y, x}] = pix;
            stores_sent++;
        end else begin
            pending_pixels.push_back(map_next_pixel());
            emits_sent++;
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        case (idx)
            CFG_COS:   reg_cos   = data;
            CFG_SIN:   reg_sin   = data;
            CFG_SRC_W: reg_src_w = data[SIZE_W-1:0];
            CFG_SRC_H: reg_src_h = data[SIZE_W-1:0];
            CFG_DST_W: reg_dst_w = data[SIZE_W-1:0];
            CFG_DST_H: reg_dst_h = data[SIZE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // size word with junk above the 9 size bits
    function automatic logic [CFG_DATA_W-1:0] size_word(input int v);
        logic [CFG_DATA_W-1:0] w;
        w = CFG_DATA_W'($urandom());
        w[SIZE_W-1:0] = SIZE_W'(v);
        return w;
    endfunction

    task automatic set_geometry(input logic [REG_CNT-1:0] mask, input logic [TRIG_W-1:0] cos_v,
                                input logic [TRIG_W-1:0] sin_v, input int sw, input int sh,
                                input int dw, input int dh);
        wait_drained();
        if (mask[CFG_COS])   write_reg(CFG_COS, cos_v);
        if (mask[CFG_SIN])   write_reg(CFG_SIN, sin_v);
        if (mask[CFG_SRC_W]) write_reg(CFG_SRC_W, size_word(sw));
        if (mask[CFG_SRC_H]) write_reg(CFG_SRC_H, size_word(sh));
        if (mask[CFG_DST_W]) write_reg(CFG_DST_W, size_word(dw));
        if (mask[CFG_DST_H]) write_reg(CFG_DST_H, size_word(dh));
        if ($urandom_range(0, 5) == 0)
            write_reg(CFG_SPARE, CFG_DATA_W'($urandom()));
        settings_count++;
    endtask

    // every position an emit can read must hold a written value
    task automatic fill_source();
        int sw, sh;
        sw = (reg_src_w > SIDE) ? SIDE : reg_src_w;
        sh = (reg_src_h > SIDE) ? SIDE : reg_src_h;
        for (int y = 0; y < sh; y++)
            for (int x = 0; x < sw; x++)
                send_beat(FUNC_STORE, COORD_W'(x), COORD_W'(y), $urandom());
    endtask

    task automatic run_traffic(input int n_emit, input int n_noise);
        int e, s;
        e = n_emit;
        s = n_noise;
        while (e + s > 0) begin
            if (s > 0 && (e == 0 || $urandom_range(0, e + s - 1) < s)) begin
                send_beat(FUNC_STORE, COORD_W'($urandom()), COORD_W'($urandom()), $urandom());
                s--;
            end else begin
                send_beat(FUNC_EMIT, COORD_W'($urandom()), COORD_W'($urandom()), $urandom());
                e--;
            end
            if (gap_pct != 0 && $urandom_range(0, 299) == 0)
                wait_drained();
        end
    endtask

    function automatic logic [TRIG_W-1:0] rand_trig();
        case ($urandom_range(0, 7))
            0: return 16'h4000;
            1: return 16'hC000;
            2: return '0;
            3: return TRIG_W'($urandom());
            default: return TRIG_W'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic int pick_idle();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 5;
            2: return 20;
            default: return 50;
        endcase
    endfunction

    // reset trig gives a straight copy when source and destination match
    task automatic test_identity();
        set_geometry(SIZE_REGS, COS_RST, SIN_RST, 5, 4, 5, 4);
        fill_source();
        send_beat(FUNC_STORE, 8'd0, 8'd0, 32'h0000_0000);
        send_beat(FUNC_STORE, 8'd4, 8'd3, 32'hFFFF_FFFF);
        send_beat(FUNC_STORE, 8'd255, 8'd255, $urandom());
        send_beat(FUNC_STORE, 8'd255, 8'd0, $urandom());
        send_beat(FUNC_STORE, 8'd0, 8'd255, $urandom());
        run_traffic(20, 0);
    endtask

    task automatic test_quarter_turns();
        logic [TRIG_W-1:0] cos_list [4];
        logic [TRIG_W-1:0] sin_list [4];
        cos_list = '{16'h0000, 16'hC000, 16'h0000, 16'd11585};
        sin_list = '{16'h4000, 16'h0000, 16'hC000, 16'd11585};
        for (int k = 0; k < 4; k++) begin
            set_geometry(ALL_REGS, cos_list[k], sin_list[k], 4, 3, 4, 4);
            if (k == 0)
                fill_source();
            run_traffic(16, 0);
        end
    endtask

    task automatic test_trig_extremes();
        set_geometry(ALL_REGS, 16'h8000, 16'h7FFF, 6, 6, 4, 4);
        fill_source();
        run_traffic(16, 0);
        set_geometry(TRIG_REGS, 16'h7FFF, 16'h8000, 6, 6, 4, 4);
        run_traffic(16, 0);
    endtask

    task automatic test_size_extremes();
        set_geometry(ALL_REGS, COS_RST, SIN_RST, 0, 8, 3, 3);
        run_traffic(9, 0);
        set_geometry(SIZE_REGS, COS_RST, SIN_RST, 300, 1, 363, 1);
        fill_source();
        run_traffic(363, 0);
        set_geometry(SIZE_REGS, COS_RST, SIN_RST, 1, 511, 1, 40);
        fill_source();
        run_traffic(40, 0);
        set_geometry(SIZE_REGS, COS_RST, SIN_RST, 2, 2, 0, 0);
        fill_source();
        run_traffic(3, 0);
    endtask

    // shrink a destination size while the raster counter sits past it
    task automatic test_counter_shrink();
        set_geometry(ALL_REGS, 16'd15137, 16'd6270, 8, 8, 10, 10);
        fill_source();
        run_traffic(37, 0);
        set_geometry(REG_CNT'(1) << CFG_DST_W, '0, '0, 0, 0, 4, 0);
        run_traffic(6, 0);
        set_geometry(REG_CNT'(1) << CFG_DST_H, '0, '0, 0, 0, 0, 2);
        run_traffic(10, 0);
    endtask

    task automatic test_random();
        int sw, sh, dw, dh, n_emit, n_noise;
        while (stores_sent + emits_sent < TOTAL_ITEMS - QUIET_ITEMS) begin
            gap_pct   = pick_idle();
            stall_pct = pick_idle();
            sw     = $urandom_range(0, 16);
            sh     = $urandom_range(0, 16);
            dw     = $urandom_range(0, 24);
            dh     = $urandom_range(0, 24);
            n_emit = $urandom_range(5, 50);
            case ($urandom_range(0, 9))
                0: begin
                    sw = $urandom_range(257, 511);
                    sh = 0;
                end
                1: begin
                    sw = 0;
                    sh = $urandom_range(257, 511);
                end
                2: begin
                    dw = $urandom_range(300, 511);
                    dh = 1;
                end
                default: ;
            endcase
            set_geometry(SIZE_REGS | (REG_CNT'($urandom()) & TRIG_REGS),
                         rand_trig(), rand_trig(), sw, sh, dw, dh);
            fill_source();
            n_noise = $urandom_range(0, 15);
            run_traffic(n_emit, n_noise);
        end
    endtask

    // closing stretch with no idling on either side
    task automatic test_quiet_tail();
        int left;
        gap_pct   = 0;
        stall_pct = 0;
        set_geometry(ALL_REGS, rand_trig(), rand_trig(), 8, 8, 12, 12);
        fill_source();
        left = TOTAL_ITEMS - stores_sent - emits_sent;
        if (left < 24)
            left = 24;
        run_traffic(left - 8, 8);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_identity();
        test_quarter_turns();
        test_trig_extremes();
        test_size_extremes();
        test_counter_shrink();
        test_random();
        test_quiet_tail();

        wait_drained();
        $display("Sent %0d store beats and %0d emit beats across %0d register settings.",
                 stores_sent, emits_sent, settings_count);
        $display("Checked %0d results: %0d mapped inside the source, %0d frame ends.",
                 results_checked, inside_seen, last_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
hdl/irn_pkg.sv
hdl/irn_ctrl.sv
hdl/irn_dpath.sv
hdl/image_rotate_nearest.sv
tb/image_rotate_nearest_test.sv
